FILE: rtl/lhc_pkg.sv
`default_nettype none
package lhc_pkg;

	localparam int unsigned KeyW = 64;
	localparam int unsigned HandleW = 32;
	localparam int unsigned HitsW = 32;
	localparam int unsigned EvictW = 9;

	localparam logic KIND_ACCESS = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef struct packed {
		logic kind;
		logic [KeyW-1:0] key;
		logic signed [HandleW-1:0] new_handle;
	} lhc_req_t;

	typedef struct packed {
		logic hit;
		logic signed [HandleW-1:0] handle;
		logic [EvictW-1:0] evicted_count;
	} lhc_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVICT,
		ST_INSERT,
		ST_HITWR,
		ST_RESP
	} lhc_state_t;

endpackage
`default_nettype wire

FILE: rtl/lhc_fifo.sv
`default_nettype none
module lhc_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [WIDTH-1:0] wdata,
	output logic full,
	input wire logic pop,
	output logic [WIDTH-1:0] rdata,
	output logic empty
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/lhc_engine.sv
`default_nettype none
module lhc_engine #(
	parameter int unsigned CAPACITY = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire lhc_pkg::lhc_req_t req,
	input wire logic req_empty,
	output logic req_pop,
	output lhc_pkg::lhc_res_t res,
	input wire logic res_full,
	output logic res_push
);
	import lhc_pkg::*;

	localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic [KeyW-1:0] key_mem [CAPACITY];
	logic signed [HandleW-1:0] hdl_mem [CAPACITY];
	logic [HitsW-1:0] hits_mem [CAPACITY];

	lhc_state_t state_q, state_d;
	lhc_req_t cur_q;
	lhc_res_t res_q;
	logic [CW-1:0] idx_q, occ_q, removed_q;
	logic pend_s1;
	logic [IW-1:0] idx_s1, free_q, hitidx_q;
	logic [KeyW-1:0] key_s1;
	logic signed [HandleW-1:0] hdl_s1;
	logic [HitsW-1:0] hits_s1, min_q, hit_hits_q;
	logic any_q, free_ok_q;
	logic [CAPACITY-1:0] valid_q;

	logic issue, cmp, last, hit_now, evict_eq;

	assign res = res_q;

	always_comb begin
		issue = (state_q == ST_SCAN || state_q == ST_EVICT) && (idx_q != CW'(CAPACITY));
		cmp = pend_s1 && (state_q == ST_SCAN || state_q == ST_EVICT);
		last = cmp && (idx_s1 == IW'(CAPACITY - 1));
		hit_now = (state_q == ST_SCAN) && cmp && valid_q[idx_s1] && (key_s1 == cur_q.key);
		evict_eq = (state_q == ST_EVICT) && cmp && valid_q[idx_s1] && (hits_s1 == min_q);
		req_pop = (state_q == ST_IDLE) && !req_empty;
		res_push = (state_q == ST_RESP) && !res_full;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!req_empty) begin
					state_d = (req.kind == KIND_FLUSH) ? ST_RESP : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit_now) begin
					state_d = ST_HITWR;
				end else if (last) begin
					state_d = (occ_q == CW'(CAPACITY)) ? ST_EVICT : ST_INSERT;
				end
			end
			ST_EVICT: begin
				if (last) begin
					state_d = ST_INSERT;
				end
			end
			ST_HITWR: state_d = ST_RESP;
			ST_INSERT: state_d = ST_RESP;
			ST_RESP: begin
				if (!res_full) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_s1 <= 1'b0;
			idx_q <= '0;
			valid_q <= '0;
			occ_q <= '0;
		end else begin
			state_q <= state_d;
			pend_s1 <= issue;
			if (state_q == ST_IDLE || (state_q == ST_SCAN && last)) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (req_pop && req.kind == KIND_FLUSH) begin
				valid_q <= '0;
				occ_q <= '0;
			end
			if (evict_eq) begin
				valid_q[idx_s1] <= 1'b0;
				occ_q <= occ_q - 1'b1;
			end
			if (state_q == ST_INSERT) begin
				valid_q[free_q] <= 1'b1;
				occ_q <= occ_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_pop) begin
			cur_q <= req;
			removed_q <= '0;
			any_q <= 1'b0;
			free_ok_q <= 1'b0;
			min_q <= '1;
			if (req.kind == KIND_FLUSH) begin
				res_q.hit <= 1'b0;
				res_q.handle <= '0;
				res_q.evicted_count <= EvictW'(occ_q);
			end
		end
		if (issue) begin
			key_s1 <= key_mem[idx_q[IW-1:0]];
			hdl_s1 <= hdl_mem[idx_q[IW-1:0]];
			hits_s1 <= hits_mem[idx_q[IW-1:0]];
			idx_s1 <= idx_q[IW-1:0];
		end
		if (state_q == ST_SCAN && cmp) begin
			if (valid_q[idx_s1]) begin
				// Track the smallest counter now so eviction needs one pass only.
				if (!any_q || hits_s1 < min_q) begin
					min_q <= hits_s1;
				end
				any_q <= 1'b1;
			end else if (!free_ok_q) begin
				free_q <= idx_s1;
				free_ok_q <= 1'b1;
			end
		end
		if (hit_now) begin
			hitidx_q <= idx_s1;
			hit_hits_q <= hits_s1;
			res_q.hit <= 1'b1;
			res_q.handle <= hdl_s1;
			res_q.evicted_count <= '0;
		end
		if (state_q == ST_HITWR) begin
			hits_mem[hitidx_q] <= (hit_hits_q == '1) ? hit_hits_q : hit_hits_q + 1'b1;
		end
		if (state_q == ST_EVICT && cmp && valid_q[idx_s1]) begin
			if (hits_s1 == min_q) begin
				removed_q <= removed_q + 1'b1;
				if (!free_ok_q) begin
					free_q <= idx_s1;
					free_ok_q <= 1'b1;
				end
			end else begin
				hits_mem[idx_s1] <= hits_s1 - min_q;
			end
		end
		if (state_q == ST_INSERT) begin
			key_mem[free_q] <= cur_q.key;
			hdl_mem[free_q] <= cur_q.new_handle;
			hits_mem[free_q] <= HitsW'(1);
			res_q.hit <= 1'b0;
			res_q.handle <= cur_q.new_handle;
			res_q.evicted_count <= EvictW'(removed_q);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/lfu_handle_cache_with_aging.sv
// A flush needs no scan; an access scans the entries once and ends the scan early on a hit.
// An access that misses on a full cache adds a second pass, which evicts and ages the counters.
// The engine works on one word at a time and takes the next one only once the last
// reply has been pushed into the result queue.
// Reset empties the cache and both queues at once; no clearing pass is needed.
`default_nettype none
module lfu_handle_cache_with_aging #(
	parameter int unsigned CAPACITY = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic kind,
	input wire logic [63:0] key,
	input wire logic signed [31:0] new_handle,
	output logic empty,
	input wire logic pop,
	output logic hit,
	output logic signed [31:0] handle,
	output logic [8:0] evicted_count
);
	import lhc_pkg::*;

	// Incoming words wait in a small request queue so the host can keep pushing
	// while the engine scans the entry memories.
	lhc_req_t in_req, q_req;
	logic q_empty, q_pop;
	lhc_res_t eng_res, out_res;
	logic res_full, res_push;

	assign in_req.kind = kind;
	assign in_req.key = key;
	assign in_req.new_handle = new_handle;

	lhc_fifo #(.WIDTH($bits(lhc_req_t)), .DEPTH(2)) u_req_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(in_req),
		.full(full),
		.pop(q_pop),
		.rdata(q_req),
		.empty(q_empty)
	);

	// The engine looks each key up with one sequential scan. During that scan it
	// also finds the lowest free slot and the smallest counter, so a miss on a
	// full cache needs only one more pass that evicts and ages the counters.
	lhc_engine #(.CAPACITY(CAPACITY)) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.req(q_req),
		.req_empty(q_empty),
		.req_pop(q_pop),
		.res(eng_res),
		.res_full(res_full),
		.res_push(res_push)
	);

	// Finished result words sit here until the consumer pops them.
	lhc_fifo #(.WIDTH($bits(lhc_res_t)), .DEPTH(2)) u_res_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.wdata(eng_res),
		.full(res_full),
		.pop(pop),
		.rdata(out_res),
		.empty(empty)
	);

	assign hit = out_res.hit;
	assign handle = out_res.handle;
	assign evicted_count = out_res.evicted_count;
endmodule
`default_nettype wire

FILE: test/tb_lfu_handle_cache_with_aging.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_lfu_handle_cache_with_aging;
	import lhc_pkg::*;

	localparam int unsigned SLOTS = 256;
	localparam int unsigned STALL_LIMIT = 40000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic kind = KIND_ACCESS;
	logic [63:0] key = '0;
	logic signed [31:0] new_handle = '0;
	logic empty;
	logic pop = 1'b0;
	logic hit;
	logic signed [31:0] handle;
	logic [8:0] evicted_count;

	lfu_handle_cache_with_aging u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .kind(kind), .key(key),
		.new_handle(new_handle), .empty(empty), .pop(pop), .hit(hit), .handle(handle),
		.evicted_count(evicted_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Private copy of the cache contents, used to predict every reply word.
	logic slot_used [SLOTS];
	logic [63:0] slot_key [SLOTS];
	logic [31:0] slot_handle [SLOTS];
	logic [31:0] slot_hits [SLOTS];
	int unsigned fill_level;

	lhc_req_t pending_words[$];
	lhc_res_t expected_replies[$];
	int unsigned errors = 0;
	int unsigned accepted_in = 0;
	int unsigned accepted_out = 0;
	int unsigned hits_seen = 0;
	int unsigned evictions_seen = 0;
	int unsigned flushes_seen = 0;
	bit hold_off = 1'b0;
	bit steady = 1'b0;
	int unsigned idle_cycles = 0;

	// Predicts the reply to one request word and updates the private cache copy.
	function automatic lhc_res_t predict_reply(lhc_req_t req);
		lhc_res_t r;
		logic [31:0] least;
		bit found;
		int unsigned removed;
		r = '0;
		removed = 0;
		if (req.kind == KIND_FLUSH) begin
			r.evicted_count = fill_level[8:0];
			foreach (slot_used[i]) slot_used[i] = 1'b0;
			fill_level = 0;
			return r;
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_used[i] && slot_key[i] == req.key) begin
				if (slot_hits[i] != 32'hFFFF_FFFF)
					slot_hits[i]++;
				r.hit = 1'b1;
				r.handle = slot_handle[i];
				return r;
			end
		end
		if (fill_level >= SLOTS) begin
			// Drop every entry at the minimum count, then age the survivors by it.
			found = 1'b0;
			least = '1;
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_used[i] && (!found || slot_hits[i] < least)) begin
					least = slot_hits[i];
					found = 1'b1;
				end
			end
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_used[i]) begin
					if (slot_hits[i] == least) begin
						slot_used[i] = 1'b0;
						removed++;
					end else begin
						slot_hits[i] -= least;
					end
				end
			end
			fill_level -= removed;
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (!slot_used[i]) begin
				slot_used[i] = 1'b1;
				slot_key[i] = req.key;
				slot_handle[i] = req.new_handle;
				slot_hits[i] = 32'd1;
				fill_level++;
				break;
			end
		end
		r.handle = req.new_handle;
		r.evicted_count = removed[8:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		$display("MISMATCH reply %0d %s: got %0h expected %0h", accepted_out, what, got, want);
	endtask

	task automatic queue_word(input logic k, input logic [63:0] kv, input logic [31:0] hv);
		lhc_req_t w;
		w.kind = k;
		w.key = kv;
		w.new_handle = hv;
		pending_words.push_back(w);
	endtask

	function automatic logic [63:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	// Driver: the push line only drops when the queue runs dry or a random gap is chosen.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				accepted_in++;
				if (kind == KIND_FLUSH) flushes_seen++;
				expected_replies.push_back(predict_reply({kind, key, new_handle}));
				void'(pending_words.pop_front());
			end
			if (pending_words.size() > 0 && (steady || $urandom_range(99) >= 33)) begin
				push <= 1'b1;
				kind <= pending_words[0].kind;
				key <= pending_words[0].key;
				new_handle <= pending_words[0].new_handle;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Monitor: compares each accepted reply with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				accepted_out++;
				if (expected_replies.size() == 0) begin
					report_mismatch("unexpected reply", 64'(evicted_count), 64'(0));
				end else begin
					lhc_res_t e;
					e = expected_replies.pop_front();
					if (hit !== e.hit) report_mismatch("hit", 64'(hit), 64'(e.hit));
					if (handle !== e.handle)
						report_mismatch("handle", 64'(handle), 64'(e.handle));
					if (evicted_count !== e.evicted_count)
						report_mismatch("evicted_count", 64'(evicted_count),
							64'(e.evicted_count));
					if (e.hit) hits_seen++;
					if (e.evicted_count != 0) evictions_seen++;
				end
			end
			pop <= !hold_off && (steady || $urandom_range(99) >= 33);
		end
	end

	// Watchdog: counts cycles in which neither side moves a word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Watchdog expired with %0d replies outstanding",
					expected_replies.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (pending_words.size() > 0 || push || expected_replies.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		logic [63:0] hot_keys [8];
		foreach (slot_used[i]) slot_used[i] = 1'b0;
		fill_level = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extreme keys and handles, a hit, flushes of an empty and a used cache.
		queue_word(KIND_FLUSH, '0, '0);
		queue_word(KIND_ACCESS, '0, 32'h8000_0000);
		queue_word(KIND_ACCESS, '1, 32'h7FFF_FFFF);
		queue_word(KIND_ACCESS, 64'h5555_5555_5555_5555, 32'hFFFF_FFFF);
		queue_word(KIND_ACCESS, 64'hAAAA_AAAA_AAAA_AAAA, 32'h0);
		queue_word(KIND_ACCESS, '1, 32'h1234_5678);
		queue_word(KIND_ACCESS, '0, 32'h0);
		queue_word(KIND_FLUSH, '1, '1);
		queue_word(KIND_ACCESS, '1, 32'h1);
		wait_drained();

		// Fill the cache to capacity, lift some counts, then force eviction with ties.
		for (int i = 0; i < SLOTS; i++)
			queue_word(KIND_ACCESS, 64'h100 + i, $urandom);
		for (int i = 0; i < 6; i++)
			queue_word(KIND_ACCESS, 64'h100 + i, $urandom);
		queue_word(KIND_ACCESS, 64'h100, $urandom);
		queue_word(KIND_ACCESS, 64'hDEAD_0000, $urandom);
		queue_word(KIND_ACCESS, 64'hDEAD_0001, $urandom);
		wait_drained();

		// Back pressure: the receiver stalls long enough for the block to fill up.
		hold_off <= 1'b1;
		for (int i = 0; i < 40; i++)
			queue_word(KIND_ACCESS, rand_key(), $urandom);
		repeat (3000) @(posedge clk);
		hold_off <= 1'b0;
		wait_drained();

		// Random traffic: a small hot set so hits, aging and evictions all recur.
		foreach (hot_keys[i]) hot_keys[i] = rand_key();
		for (int n = 0; n < 800; n++) begin
			int unsigned pick;
			pick = $urandom_range(99);
			if (n == 300) steady <= 1'b1;
			if (n == 420) steady <= 1'b0;
			if (pick < 2)
				queue_word(KIND_FLUSH, rand_key(), $urandom);
			else if (pick < 40)
				queue_word(KIND_ACCESS, hot_keys[$urandom_range(7)], $urandom);
			else if (pick < 70)
				queue_word(KIND_ACCESS, {56'h0, 8'($urandom)}, $urandom);
			else
				queue_word(KIND_ACCESS, rand_key(), $urandom);
			if (pending_words.size() > 20)
				while (pending_words.size() > 4) @(posedge clk);
		end
		wait_drained();
		repeat (600) @(posedge clk);

		$display("Covered %0d requests and %0d replies: %0d hits, %0d evicting replies.",
			accepted_in, accepted_out, hits_seen, evictions_seen);
		$display("The traffic included %0d flushes, a full-cache tie eviction and a long stall.",
			flushes_seen);
		if (errors == 0 && expected_replies.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches, %0d replies missing", errors, expected_replies.size());
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
